// ===== hw/rtl/css_pkg.sv =====
package css_pkg;

  localparam int FREQ_ROWS_DEF = 256;
  localparam int MAX_BINS_DEF  = 64;

  // chirp numbers at which the step set changes
  localparam logic [8:0] QUARTER_START = 9'd8;
  localparam logic [8:0] DATA_START    = 9'd10;

  localparam int FREQ_DEPTH  = 256;
  localparam int ADDR_CALC_W = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [1:0] {
    FN_TICK      = 2'd0,
    FN_LOAD_SEQ  = 2'd1,
    FN_LOAD_FREQ = 2'd2,
    FN_START     = 2'd3
  } css_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_INT_NORMAL   = 3'd0,
    REG_STEP_FRAC_NORMAL  = 3'd1,
    REG_BINS_NORMAL       = 3'd2,
    REG_STEP_INT_QUARTER  = 3'd3,
    REG_STEP_FRAC_QUARTER = 3'd4,
    REG_BINS_QUARTER      = 3'd5,
    REG_FRAC_MODULUS      = 3'd6,
    REG_TOTAL_CHIRPS      = 3'd7
  } css_reg_e;

  typedef enum logic {
    ST_TAKE = 1'b0,
    ST_ROW  = 1'b1
  } css_state_t;

  typedef struct packed {
    logic [15:0] step_int_normal;
    logic [15:0] step_frac_normal;
    logic [6:0]  bins_normal;
    logic [15:0] step_int_quarter;
    logic [15:0] step_frac_quarter;
    logic [6:0]  bins_quarter;
    logic [16:0] frac_modulus;
    logic [8:0]  total_chirps;
  } css_cfg_t;

endpackage

// ===== hw/rtl/css_if.sv =====
interface css_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  row_index;
  logic [5:0]  bin_index;
  logic [7:0]  load_data;
  logic [31:0] start_time;

  modport source (output valid, func, row_index, bin_index, load_data, start_time,
                  input ready);
  modport sink (input valid, func, row_index, bin_index, load_data, start_time,
                output ready);
endinterface

interface css_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_match;
  logic [7:0]  serial_byte;
  logic        byte_valid;
  logic        done_res;

  modport source (output valid, next_match, serial_byte, byte_valid, done_res,
                  input ready);
  modport sink (input valid, next_match, serial_byte, byte_valid, done_res,
                output ready);
endinterface

// ===== hw/rtl/chirp_symbol_scheduler.sv =====
// output: a result sits in the output register in the cycle after its item is accepted
// throughput: one item per cycle outside ST_ROW; a start, or a tick ending any chirp but
// the last, enters it; the chirp row read must return before the dependent sequence read
// input also stalls while a result waits in the output register and the receiver holds off
// reset: synchronous, active low; clears counters, flags and registers to defaults
// the two tables are not cleared and hold nothing defined until loaded
module chirp_symbol_scheduler #(
  parameter int FREQ_ROWS = css_pkg::FREQ_ROWS_DEF,
  parameter int MAX_BINS  = css_pkg::MAX_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  css_in_if.sink                         in_ch,
  css_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [css_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SEQ_DEPTH = FREQ_ROWS * MAX_BINS;
  localparam int SEQ_AW    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int AW        = css_pkg::ADDR_CALC_W;

  css_pkg::css_cfg_t   cfg;
  css_pkg::css_state_t state_r, state_nxt;

  css_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // scheduler state
  logic [31:0] match_r, match_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [6:0]  bin_r, bin_nxt;
  logic [8:0]  chirp_r, chirp_nxt;
  logic        quarter_r, quarter_nxt;
  logic [7:0]  row_r, row_nxt;
  logic        running_r, running_nxt;
  logic        done_r, done_nxt;
  logic        word_null_r, word_null_nxt;

  // tables
  logic [7:0] seq_mem [SEQ_DEPTH];
  logic [7:0] freq_mem [css_pkg::FREQ_DEPTH];
  logic [7:0] seq_rd_r;
  logic [7:0] freq_rd_r;

  logic              seq_re, seq_we, freq_re, freq_we;
  logic [SEQ_AW-1:0] seq_ra, seq_wa;
  logic [7:0]        freq_ra;
  logic [7:0]        seq_row;
  logic [6:0]        seq_bin;
  logic              seq_in_range;
  logic [AW-1:0]     seq_ra_full, seq_wa_full;
  logic              need_row;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_match_r;
  logic [7:0]  out_byte_r;
  logic        out_bvalid_r;
  logic        out_done_r;

  logic                accept, is_tick, is_start, row_fetch;
  css_pkg::css_func_e  func;
  logic [7:0]          cur_word;

  // tick arithmetic
  logic [15:0] si, sf;
  logic [6:0]  nb;
  logic [16:0] frac_sum, frac_left;
  logic        carry;
  logic [31:0] match_step;
  logic [6:0]  bin_inc;
  logic [8:0]  chirp_inc;
  logic        wrap;

  assign func     = css_pkg::css_func_e'(in_ch.func);
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_tick  = accept && (func == css_pkg::FN_TICK) && running_r;
  assign is_start = accept && (func == css_pkg::FN_START);
  assign cur_word = word_null_r ? 8'd0 : seq_rd_r;

  always_comb begin
    si         = quarter_r ? cfg.step_int_quarter  : cfg.step_int_normal;
    sf         = quarter_r ? cfg.step_frac_quarter : cfg.step_frac_normal;
    nb         = quarter_r ? cfg.bins_quarter      : cfg.bins_normal;
    frac_sum   = {1'b0, frac_r} + {1'b0, sf};
    carry      = (frac_sum >= cfg.frac_modulus);
    frac_left  = carry ? (frac_sum - cfg.frac_modulus) : frac_sum;
    match_step = match_r + {16'd0, si} + {31'd0, carry};
    bin_inc    = bin_r + 7'd1;
    chirp_inc  = chirp_r + 9'd1;
    wrap       = (bin_inc == nb);
  end

  // next state of the scheduler and table accesses
  always_comb begin
    match_nxt     = match_r;
    frac_nxt      = frac_r;
    bin_nxt       = bin_r;
    chirp_nxt     = chirp_r;
    quarter_nxt   = quarter_r;
    row_nxt       = row_r;
    running_nxt   = running_r;
    done_nxt      = done_r;
    need_row      = 1'b0;
    freq_ra       = 8'd0;
    seq_row       = row_r;
    seq_bin       = bin_inc;
    seq_re        = 1'b0;

    if (row_fetch) begin
      // chirp row has come back: fetch the first byte of that row
      row_nxt = freq_rd_r;
      seq_row = freq_rd_r;
      seq_bin = 7'd0;
      seq_re  = 1'b1;
    end

    if (is_start) begin
      match_nxt   = in_ch.start_time;
      frac_nxt    = 16'd0;
      bin_nxt     = 7'd0;
      chirp_nxt   = 9'd0;
      quarter_nxt = 1'b0;
      running_nxt = 1'b1;
      done_nxt    = 1'b0;
      need_row    = 1'b1;
      freq_ra     = 8'd0;
    end

    if (is_tick) begin
      match_nxt = match_step;
      frac_nxt  = frac_left[15:0];
      if (wrap) begin
        bin_nxt   = 7'd0;
        chirp_nxt = chirp_inc;
        freq_ra   = chirp_inc[7:0];
        priority if (chirp_inc == css_pkg::QUARTER_START) begin
          quarter_nxt = 1'b1;
          need_row    = 1'b1;
        end else if (chirp_inc == css_pkg::DATA_START) begin
          quarter_nxt = 1'b0;
          need_row    = 1'b1;
        end else if (chirp_inc == cfg.total_chirps) begin
          running_nxt = 1'b0;
          done_nxt    = 1'b1;
        end else begin
          need_row = 1'b1;
        end
      end else begin
        bin_nxt = bin_inc;
        seq_re  = 1'b1;
      end
    end

    freq_re       = need_row;
    seq_in_range  = ({1'b0, seq_row} < 9'(FREQ_ROWS)) && (seq_bin < 7'(MAX_BINS));
    seq_ra_full   = AW'(seq_row) * AW'(MAX_BINS) + AW'(seq_bin);
    seq_ra        = seq_ra_full[SEQ_AW-1:0];
    word_null_nxt = seq_re ? !seq_in_range : word_null_r;
  end

  // table writes
  always_comb begin
    seq_we      = accept && (func == css_pkg::FN_LOAD_SEQ) &&
                  ({1'b0, in_ch.row_index} < 9'(FREQ_ROWS)) &&
                  ({1'b0, in_ch.bin_index} < 7'(MAX_BINS));
    seq_wa_full = AW'(in_ch.row_index) * AW'(MAX_BINS) + AW'(in_ch.bin_index);
    seq_wa      = seq_wa_full[SEQ_AW-1:0];
    freq_we     = accept && (func == css_pkg::FN_LOAD_FREQ);
  end

  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[seq_wa] <= in_ch.load_data;
    end
    if (seq_re && seq_in_range) begin
      seq_rd_r <= seq_mem[seq_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[in_ch.row_index] <= in_ch.load_data;
    end
    if (freq_re) begin
      freq_rd_r <= freq_mem[freq_ra];
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      css_pkg::ST_TAKE: if (need_row) state_nxt = css_pkg::ST_ROW;
      css_pkg::ST_ROW:  state_nxt = css_pkg::ST_TAKE;
      default:          state_nxt = css_pkg::ST_TAKE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ch.ready = 1'b0;
    row_fetch   = 1'b0;
    unique case (state_r)
      css_pkg::ST_TAKE: in_ch.ready = !out_valid_r || out_ch.ready;
      css_pkg::ST_ROW:  row_fetch   = 1'b1;
      default: ;
    endcase
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= css_pkg::ST_TAKE;
      match_r     <= 32'd0;
      frac_r      <= 16'd0;
      bin_r       <= 7'd0;
      chirp_r     <= 9'd0;
      quarter_r   <= 1'b0;
      row_r       <= 8'd0;
      running_r   <= 1'b0;
      done_r      <= 1'b0;
      word_null_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      match_r     <= match_nxt;
      frac_r      <= frac_nxt;
      bin_r       <= bin_nxt;
      chirp_r     <= chirp_nxt;
      quarter_r   <= quarter_nxt;
      row_r       <= row_nxt;
      running_r   <= running_nxt;
      done_r      <= done_nxt;
      word_null_r <= word_null_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_match_r  <= match_nxt;
      out_byte_r   <= is_tick ? cur_word : 8'd0;
      out_bvalid_r <= is_tick;
      out_done_r   <= done_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_match  = out_match_r;
  assign out_ch.serial_byte = out_byte_r;
  assign out_ch.byte_valid  = out_bvalid_r;
  assign out_ch.done_res    = out_done_r;

`ifndef NO_ASSERTIONS
  a_row_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == css_pkg::ST_ROW |=> state_r == css_pkg::ST_TAKE)
    else $error("row fetch phase lasted more than one cycle");

  a_no_accept_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == css_pkg::ST_ROW |-> !in_ch.ready)
    else $error("item taken while the chirp row read is in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("accepted item gave no result");

  a_run_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(running_r && done_r))
    else $error("running and done flags both set");
`endif

endmodule

// ===== hw/rtl/css_cfg.sv =====
module css_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [css_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [css_pkg::CFG_DATA_W-1:0]    cfg_data,
  output css_pkg::css_cfg_t                 cfg
);

  css_pkg::css_cfg_t cfg_r;
  css_pkg::css_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (css_pkg::css_reg_e'(cfg_index))
        css_pkg::REG_STEP_INT_NORMAL:   cfg_nxt.step_int_normal   = cfg_data[15:0];
        css_pkg::REG_STEP_FRAC_NORMAL:  cfg_nxt.step_frac_normal  = cfg_data[15:0];
        css_pkg::REG_BINS_NORMAL:       cfg_nxt.bins_normal       = cfg_data[6:0];
        css_pkg::REG_STEP_INT_QUARTER:  cfg_nxt.step_int_quarter  = cfg_data[15:0];
        css_pkg::REG_STEP_FRAC_QUARTER: cfg_nxt.step_frac_quarter = cfg_data[15:0];
        css_pkg::REG_BINS_QUARTER:      cfg_nxt.bins_quarter      = cfg_data[6:0];
        css_pkg::REG_FRAC_MODULUS:      cfg_nxt.frac_modulus      = cfg_data[16:0];
        css_pkg::REG_TOTAL_CHIRPS:      cfg_nxt.total_chirps      = cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_int_normal   <= 16'd0;
      cfg_r.step_frac_normal  <= 16'd0;
      cfg_r.bins_normal       <= 7'd64;
      cfg_r.step_int_quarter  <= 16'd0;
      cfg_r.step_frac_quarter <= 16'd0;
      cfg_r.bins_quarter      <= 7'd16;
      cfg_r.frac_modulus      <= 17'd1;
      cfg_r.total_chirps      <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== tb/css_tb_pkg.sv =====
package css_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import css_pkg::*;

  typedef struct packed {
    css_func_e   func;
    logic [7:0]  row_index;
    logic [5:0]  bin_index;
    logic [7:0]  load_data;
    logic [31:0] start_time;
  } sched_item_t;

  typedef struct packed {
    logic [31:0] next_match;
    logic [7:0]  serial_byte;
    logic        byte_valid;
    logic        done_res;
  } sched_result_t;

  class symbol_scoreboard;
    css_cfg_t      regs;
    logic [31:0]   match_time;
    logic [15:0]   frac_acc;
    logic [6:0]    bin_count;
    logic [8:0]    chirp_count;
    logic          quarter_mode;
    logic [7:0]    cur_word;
    logic [7:0]    cur_row;
    logic          running;
    logic          done;
    logic [7:0]    seq_mem [FREQ_ROWS_DEF*MAX_BINS_DEF];
    bit            seq_loaded [FREQ_ROWS_DEF*MAX_BINS_DEF];
    logic [7:0]    row_of_chirp [FREQ_DEPTH];
    bit            row_loaded [FREQ_DEPTH];
    sched_result_t expected_symbols[$];
    int            errors;
    int            items_seen;
    int            bytes_sent;
    int            starts;
    int            completions;

    function new();
      regs = '0;
      regs.bins_normal = 7'd64;
      regs.bins_quarter = 7'd16;
      regs.frac_modulus = 17'd1;
      regs.total_chirps = 9'd256;
      match_time = '0;
      frac_acc = '0;
      bin_count = '0;
      chirp_count = '0;
      quarter_mode = 1'b0;
      cur_word = '0;
      cur_row = '0;
      running = 1'b0;
      done = 1'b0;
      errors = 0;
      items_seen = 0;
      bytes_sent = 0;
      starts = 0;
      completions = 0;
    endfunction

    function void write_reg(css_reg_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_STEP_INT_NORMAL:   regs.step_int_normal = v[15:0];
        REG_STEP_FRAC_NORMAL:  regs.step_frac_normal = v[15:0];
        REG_BINS_NORMAL:       regs.bins_normal = v[6:0];
        REG_STEP_INT_QUARTER:  regs.step_int_quarter = v[15:0];
        REG_STEP_FRAC_QUARTER: regs.step_frac_quarter = v[15:0];
        REG_BINS_QUARTER:      regs.bins_quarter = v[6:0];
        REG_FRAC_MODULUS:      regs.frac_modulus = v[16:0];
        REG_TOTAL_CHIRPS:      regs.total_chirps = v[8:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] seq_at(logic [7:0] row, logic [6:0] bin);
      if (bin >= MAX_BINS_DEF) return 8'h00;
      return seq_mem[row * MAX_BINS_DEF + bin];
    endfunction

    function sched_result_t predict_symbol(sched_item_t it);
      sched_result_t r;
      logic [15:0]   si;
      logic [15:0]   sf;
      logic [6:0]    nb;
      logic [17:0]   acc;
      logic          stopped;
      r = '0;
      case (it.func)
        FN_TICK: begin
          if (running) begin
            si = quarter_mode ? regs.step_int_quarter : regs.step_int_normal;
            sf = quarter_mode ? regs.step_frac_quarter : regs.step_frac_normal;
            nb = quarter_mode ? regs.bins_quarter : regs.bins_normal;
            match_time = match_time + si;
            acc = frac_acc + sf;
            // one carry at most per tick
            if (acc >= regs.frac_modulus) begin
              acc = acc - regs.frac_modulus;
              match_time = match_time + 32'd1;
            end
            frac_acc = acc[15:0];
            r.serial_byte = cur_word;
            r.byte_valid = 1'b1;
            stopped = 1'b0;
            bin_count = bin_count + 7'd1;
            if (bin_count == nb) begin
              chirp_count = chirp_count + 9'd1;
              bin_count = '0;
              // quarter check wins over data check, both win over the total
              if (chirp_count == QUARTER_START) begin
                quarter_mode = 1'b1;
              end else if (chirp_count == DATA_START) begin
                quarter_mode = 1'b0;
              end else if (chirp_count == regs.total_chirps) begin
                running = 1'b0;
                done = 1'b1;
                stopped = 1'b1;
                completions++;
              end
              if (!stopped) cur_row = row_of_chirp[chirp_count[7:0]];
            end
            if (!stopped) cur_word = seq_at(cur_row, bin_count);
          end
        end
        FN_LOAD_SEQ: begin
          seq_mem[it.row_index * MAX_BINS_DEF + it.bin_index] = it.load_data;
          seq_loaded[it.row_index * MAX_BINS_DEF + it.bin_index] = 1'b1;
        end
        FN_LOAD_FREQ: begin
          row_of_chirp[it.row_index] = it.load_data;
          row_loaded[it.row_index] = 1'b1;
        end
        default: begin
          match_time = it.start_time;
          frac_acc = '0;
          bin_count = '0;
          chirp_count = '0;
          quarter_mode = 1'b0;
          running = 1'b1;
          done = 1'b0;
          cur_row = row_of_chirp[0];
          cur_word = seq_at(cur_row, 7'd0);
        end
      endcase
      r.next_match = match_time;
      r.done_res = done;
      return r;
    endfunction

    // finds a table entry this item would read before anything was loaded there
    function bit missing_entry(sched_item_t it, output sched_item_t fix);
      logic [6:0] nb;
      logic [6:0] b;
      logic [8:0] c;
      logic [7:0] row;
      fix = '0;
      fix.load_data = 8'($urandom);
      fix.start_time = $urandom;
      fix.bin_index = 6'($urandom);
      if (it.func == FN_START) begin
        if (!row_loaded[0]) begin
          fix.func = FN_LOAD_FREQ;
          fix.row_index = 8'd0;
          return 1'b1;
        end
        row = row_of_chirp[0];
        b = '0;
      end else if (it.func == FN_TICK && running) begin
        nb = quarter_mode ? regs.bins_quarter : regs.bins_normal;
        b = bin_count + 7'd1;
        row = cur_row;
        if (b == nb) begin
          c = chirp_count + 9'd1;
          b = '0;
          if (c != QUARTER_START && c != DATA_START && c == regs.total_chirps) return 1'b0;
          if (!row_loaded[c[7:0]]) begin
            fix.func = FN_LOAD_FREQ;
            fix.row_index = c[7:0];
            return 1'b1;
          end
          row = row_of_chirp[c[7:0]];
        end
      end else begin
        return 1'b0;
      end
      if (b < MAX_BINS_DEF && !seq_loaded[row * MAX_BINS_DEF + b]) begin
        fix.func = FN_LOAD_SEQ;
        fix.row_index = row;
        fix.bin_index = b[5:0];
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(sched_item_t it);
      sched_result_t r;
      r = predict_symbol(it);
      items_seen++;
      if (r.byte_valid) bytes_sent++;
      if (it.func == FN_START) starts++;
      expected_symbols.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp_r;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: unexpected result match %h byte %h valid %b done %b", $time,
                 got.next_match, got.serial_byte, got.byte_valid, got.done_res);
        return;
      end
      exp_r = expected_symbols.pop_front();
      if (got.next_match !== exp_r.next_match) begin
        errors++;
        $display("%0t: next_match expected %h actual %h", $time,
                 exp_r.next_match, got.next_match);
      end
      if (got.serial_byte !== exp_r.serial_byte) begin
        errors++;
        $display("%0t: serial_byte expected %h actual %h", $time,
                 exp_r.serial_byte, got.serial_byte);
      end
      if (got.byte_valid !== exp_r.byte_valid) begin
        errors++;
        $display("%0t: byte_valid expected %b actual %b", $time,
                 exp_r.byte_valid, got.byte_valid);
      end
      if (got.done_res !== exp_r.done_res) begin
        errors++;
        $display("%0t: done_res expected %b actual %b", $time, exp_r.done_res, got.done_res);
      end
    endfunction

    function int outstanding();
      return expected_symbols.size();
    endfunction

    function void flag_leftover();
      if (expected_symbols.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived, next expected match %h", $time,
                 expected_symbols.size(), expected_symbols[0].next_match);
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import css_pkg::*;
  import css_tb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  css_in_if  in_ch();
  css_out_if out_ch();

  chirp_symbol_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  symbol_scoreboard sb;
  int burst_left;
  int settings_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic sched_item_t make_item(css_func_e f, logic [7:0] row, logic [5:0] bin,
                                            logic [7:0] data, logic [31:0] st);
    sched_item_t it;
    it.func = f;
    it.row_index = row;
    it.bin_index = bin;
    it.load_data = data;
    it.start_time = st;
    return it;
  endfunction

  function automatic sched_item_t random_fields(css_func_e f);
    return make_item(f, 8'($urandom), 6'($urandom), 8'($urandom), $urandom);
  endfunction

  function automatic css_cfg_t settings(logic [15:0] sin, logic [15:0] sfn, logic [6:0] bn,
                                        logic [15:0] siq, logic [15:0] sfq, logic [6:0] bq,
                                        logic [16:0] md, logic [8:0] tot);
    css_cfg_t c;
    c.step_int_normal = sin;
    c.step_frac_normal = sfn;
    c.bins_normal = bn;
    c.step_int_quarter = siq;
    c.step_frac_quarter = sfq;
    c.bins_quarter = bq;
    c.frac_modulus = md;
    c.total_chirps = tot;
    return c;
  endfunction

  function automatic logic [15:0] pick16();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic css_cfg_t random_settings();
    css_cfg_t    c;
    logic [15:0] fmax;
    c.step_int_normal = pick16();
    c.step_frac_normal = pick16();
    c.step_int_quarter = pick16();
    c.step_frac_quarter = pick16();
    fmax = (c.step_frac_normal > c.step_frac_quarter) ? c.step_frac_normal
                                                      : c.step_frac_quarter;
    // modulus stays above both fractional steps
    if ($urandom_range(0, 5) == 0) c.frac_modulus = 17'(int'(fmax) + 1);
    else c.frac_modulus = 17'($urandom_range(int'(fmax) + 1, 65536));
    c.bins_normal = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(1, 64))
                                                 : 7'($urandom_range(1, 4));
    c.bins_quarter = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(1, 64))
                                                  : 7'($urandom_range(1, 4));
    if ($urandom_range(0, 5) == 0) c.total_chirps = $urandom_range(0, 1) ? QUARTER_START
                                                                         : DATA_START;
    else c.total_chirps = 9'($urandom_range(1, 14));
    return c;
  endfunction

  task automatic send_item(sched_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.row_index <= it.row_index;
    in_ch.bin_index <= it.bin_index;
    in_ch.load_data <= it.load_data;
    in_ch.start_time <= it.start_time;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    burst_left--;
  endtask

  // loads any table entry the item would otherwise read undefined
  task automatic issue(sched_item_t it);
    sched_item_t fix;
    while (sb.missing_entry(it, fix)) send_item(fix);
    send_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(css_cfg_t c);
    int                    i;
    css_reg_e              r;
    logic [CFG_DATA_W-1:0] v;
    drain();
    for (i = 0; i < 8; i++) begin
      r = css_reg_e'(i);
      case (r)
        REG_STEP_INT_NORMAL:   v = CFG_DATA_W'(c.step_int_normal);
        REG_STEP_FRAC_NORMAL:  v = CFG_DATA_W'(c.step_frac_normal);
        REG_BINS_NORMAL:       v = CFG_DATA_W'(c.bins_normal);
        REG_STEP_INT_QUARTER:  v = CFG_DATA_W'(c.step_int_quarter);
        REG_STEP_FRAC_QUARTER: v = CFG_DATA_W'(c.step_frac_quarter);
        REG_BINS_QUARTER:      v = CFG_DATA_W'(c.bins_quarter);
        REG_FRAC_MODULUS:      v = CFG_DATA_W'(c.frac_modulus);
        default:               v = CFG_DATA_W'(c.total_chirps);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_data <= v;
      @(posedge clk);
      sb.write_reg(r, v);
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic run_transmission(int max_ticks, bit restarts);
    int n;
    int pick;
    issue(random_fields(FN_START));
    n = 0;
    while (sb.running && n < max_ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        issue(random_fields(FN_LOAD_SEQ));
      end else if (pick < 9) begin
        issue(random_fields(FN_LOAD_FREQ));
      end else if (pick < 10 && restarts) begin
        // broken chirp sequence: start again mid-chirp
        issue(random_fields(FN_START));
      end else begin
        issue(random_fields(FN_TICK));
        n++;
      end
    end
    // up to two more ticks after the stop or after the tick budget runs out
    repeat ($urandom_range(0, 2)) issue(random_fields(FN_TICK));
  endtask

  initial begin
    int w;
    sb = new();
    burst_left = 0;
    settings_done = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FN_TICK;
    in_ch.row_index <= '0;
    in_ch.bin_index <= '0;
    in_ch.load_data <= '0;
    in_ch.start_time <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, table extremes, wrap of the match time
    issue(random_fields(FN_TICK));
    issue(make_item(FN_LOAD_FREQ, 8'd0, 6'd0, 8'hFF, 32'd0));
    issue(make_item(FN_LOAD_FREQ, 8'hFF, 6'h3F, 8'h00, 32'hFFFF_FFFF));
    issue(make_item(FN_LOAD_SEQ, 8'hFF, 6'd0, 8'hA5, 32'd0));
    issue(make_item(FN_LOAD_SEQ, 8'hFF, 6'h3F, 8'hFF, 32'd0));
    issue(make_item(FN_LOAD_SEQ, 8'hFF, 6'd1, 8'h00, 32'd0));
    issue(make_item(FN_LOAD_SEQ, 8'd0, 6'd0, 8'h00, 32'd0));
    issue(make_item(FN_START, 8'd0, 6'd0, 8'd0, 32'hFFFF_FFFF));
    repeat (3) issue(random_fields(FN_TICK));
    // one bin per chirp, two chirps: carry on the second tick, then the final chirp
    apply_settings(settings(16'hFFFF, 16'hFFFF, 7'd1, 16'd0, 16'd0, 7'd1, 17'h10000, 9'd2));
    issue(make_item(FN_START, 8'd0, 6'd0, 8'd0, 32'hFFFF_0000));
    repeat (3) issue(random_fields(FN_TICK));
    issue(make_item(FN_START, 8'hFF, 6'h3F, 8'hFF, 32'd0));
    issue(random_fields(FN_TICK));

    // extremes of the settings
    apply_settings(settings(16'hFFFF, 16'hFFFF, 7'd64, 16'hFFFF, 16'hFFFF, 7'd64,
                            17'h10000, 9'd2));
    run_transmission(200, 1'b0);
    apply_settings(settings(16'd0, 16'd0, 7'd1, 16'd0, 16'd0, 7'd1, 17'd1, 9'd256));
    run_transmission(300, 1'b0);
    // total on the quarter chirp never stops, so the chirp counter wraps
    apply_settings(settings(pick16(), 16'd100, 7'd1, pick16(), 16'd7, 7'd1, 17'd101,
                            QUARTER_START));
    run_transmission(540, 1'b0);
    apply_settings(settings(pick16(), 16'd0, 7'd3, pick16(), 16'd65535, 7'd2, 17'h10000,
                            DATA_START));
    run_transmission(60, 1'b1);
    apply_settings(settings(16'd1, 16'd1, 7'd1, 16'd1, 16'd1, 7'd1, 17'd2, 9'd1));
    run_transmission(10, 1'b0);

    // random settings at least once, then until the item budget is spent
    do begin
      apply_settings(random_settings());
      repeat ($urandom_range(1, 3)) run_transmission(120, 1'b1);
    end while (sb.items_seen < 1850);

    drain();
    for (w = 0; w < 16 && sb.outstanding() == 0; w++) @(posedge clk);
    sb.flag_leftover();
    $display("covered %0d items: %0d bytes sent, %0d starts, %0d transmissions ended",
             sb.items_seen, sb.bytes_sent, sb.starts, sb.completions);
    $display("across %0d register settings", settings_done);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: stall pattern is re-picked at random from four modes, plus two long hold-offs
  initial begin
    int cyc;
    int hold_left;
    int mode;
    int holds_done;
    out_ch.ready <= 1'b0;
    cyc = 0;
    hold_left = 0;
    mode = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.next_match, out_ch.serial_byte, out_ch.byte_valid,
                          out_ch.done_res});
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_left == 0 && holds_done < 2 && cyc > 1500 * (holds_done + 1) && in_ch.valid)
      begin
        hold_left = 300;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= (cyc % 2 == 0);
          2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

endmodule
